// ===== rtl/ssstat_pkg.sv =====
// shared constants, types and helpers for the sample set statistics block
`default_nettype none

package ssstat_pkg;

   localparam int MAX_SAMPLES = 4096;
   localparam int SAMPLE_BITS = 16;
   localparam int SMP_W       = 16;
   localparam int SX_BITS     = (SAMPLE_BITS < SMP_W) ? SAMPLE_BITS : SMP_W;

   localparam int CNT_W  = 13;
   localparam int SUM_W  = 29;
   localparam int SSQ_W  = 43;
   localparam int SQ_W   = 2 * SMP_W;
   localparam int MAG_W  = 28;
   localparam int MEAN_W = 24;
   localparam int SD_W   = 23;

   localparam int SSQ_LO_W = 22;
   localparam int SSQ_HI_W = SSQ_W - SSQ_LO_W;
   localparam int PLO_W    = CNT_W + SSQ_LO_W;
   localparam int PHI_W    = CNT_W + SSQ_HI_W;
   localparam int VNUM_W   = 56;
   localparam int N2_W     = 2 * CNT_W - 1;

   localparam int DIV_W      = VNUM_W + 16;
   localparam int DVS_W      = N2_W;
   localparam int MEAN_ITERS = MAG_W + 8;
   localparam int QUOT_W     = MEAN_ITERS;
   localparam int VQ_W       = 48;
   localparam int ROOT_W     = VQ_W / 2;
   localparam int SREM_W     = ROOT_W + 2;
   localparam int ITER_W     = $clog2(DIV_W + 1);

   localparam int QUEUE_DEPTH = 2;
   localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int LVL_W       = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [CNT_W-1:0]        count;
      logic signed [SMP_W-1:0] minimum;
      logic signed [SMP_W-1:0] maximum;
      logic signed [SUM_W-1:0] sum;
      logic [SSQ_W-1:0]        sumsq;
      logic                    dropped;
   } snap_type;

   typedef struct packed {
      logic     valid;
      snap_type snap;
   } head_type;

   function automatic logic signed [SMP_W-1:0] sign_ext(input logic [SMP_W-1:0] raw);
      logic [SMP_W-1:0] v;
      v = raw;
      for (int i = SX_BITS; i < SMP_W; i++) begin
         v[i] = raw[SX_BITS-1];
      end
      return v;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/sample_set_statistics.sv =====
// top level: count, min, max, mean and population deviation of a marked set of samples
// from the edge that takes the last sample of a set to its result word: accumulate and push,
// pop, 5 multiply steps, 36 + 72 serial divide steps, 24 root steps, then the result word load
// throughput: one sample per cycle, stalled when a finished set meets a full 2-deep queue of waiting sets;
// the back end takes one set at a time through the one-bit-per-cycle divider and root unit
// reset: synchronous active-high reset clears accumulators, queue, sequencer and result valid
`default_nettype none

module sample_set_statistics (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic signed [ssstat_pkg::SMP_W-1:0]  req_sample,
   input  logic                                 req_last,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [ssstat_pkg::CNT_W-1:0]         rsp_count,
   output logic signed [ssstat_pkg::SMP_W-1:0]  rsp_minimum,
   output logic signed [ssstat_pkg::SMP_W-1:0]  rsp_maximum,
   output logic signed [ssstat_pkg::MEAN_W-1:0] rsp_mean_q8,
   output logic [ssstat_pkg::SD_W-1:0]          rsp_stddev_q8,
   output logic                                 rsp_overflow
);

   logic                  push;
   ssstat_pkg::snap_type  push_snap;
   logic                  q_full;
   logic                  pop;
   ssstat_pkg::head_type  head;

   ssstat_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_sample (req_sample),
      .req_last   (req_last),
      .push       (push),
      .push_snap  (push_snap),
      .q_full     (q_full)
   );

   ssstat_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_snap (push_snap),
      .full      (q_full),
      .pop       (pop),
      .head      (head)
   );

   ssstat_back u_back (
      .clock         (clock),
      .reset         (reset),
      .head          (head),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_count     (rsp_count),
      .rsp_minimum   (rsp_minimum),
      .rsp_maximum   (rsp_maximum),
      .rsp_mean_q8   (rsp_mean_q8),
      .rsp_stddev_q8 (rsp_stddev_q8),
      .rsp_overflow  (rsp_overflow)
   );

endmodule

`default_nettype wire

// ===== rtl/ssstat_front.sv =====
// front end: squares each sample and keeps the running count, min, max and sums
`default_nettype none

module ssstat_front (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [ssstat_pkg::SMP_W-1:0]    req_sample,
   input  logic                            req_last,
   output logic                            push,
   output ssstat_pkg::snap_type            push_snap,
   input  logic                            q_full
);

   logic                                  s1_valid_ff;
   logic                                  s1_last_ff;
   logic signed [ssstat_pkg::SMP_W-1:0]   s1_x_ff;
   logic [ssstat_pkg::SQ_W-1:0]           s1_sq_ff;
   ssstat_pkg::snap_type                  acc_ff;
   ssstat_pkg::snap_type                  acc_in;
   ssstat_pkg::snap_type                  upd;
   logic signed [ssstat_pkg::SMP_W-1:0]   req_x;
   logic                                  advance;
   logic                                  take;
   logic                                  at_limit;

   assign advance   = !(s1_valid_ff && s1_last_ff && q_full);
   assign req_ready = advance;
   assign req_x     = ssstat_pkg::sign_ext(req_sample);
   assign take      = s1_valid_ff && advance;
   assign at_limit  = 32'(acc_ff.count) >= 32'(ssstat_pkg::MAX_SAMPLES);

   always_comb begin
      upd = acc_ff;
      if (at_limit) begin
         upd.dropped = 1'b1;
      end else begin
         if (acc_ff.count == '0 || s1_x_ff < acc_ff.minimum) begin
            upd.minimum = s1_x_ff;
         end
         if (acc_ff.count == '0 || s1_x_ff > acc_ff.maximum) begin
            upd.maximum = s1_x_ff;
         end
         upd.sum   = acc_ff.sum + {{(ssstat_pkg::SUM_W-ssstat_pkg::SMP_W){s1_x_ff[ssstat_pkg::SMP_W-1]}},
                                   s1_x_ff};
         upd.sumsq = acc_ff.sumsq + ssstat_pkg::SSQ_W'(s1_sq_ff);
         upd.count = acc_ff.count + 1'b1;
      end
   end

   always_comb begin
      acc_in = acc_ff;
      if (take) begin
         acc_in = s1_last_ff ? '0 : upd;
      end
   end

   assign push      = take && s1_last_ff;
   assign push_snap = upd;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s1_last_ff  <= 1'b0;
         acc_ff      <= '0;
      end else begin
         acc_ff <= acc_in;
         if (advance) begin
            s1_valid_ff <= req_valid;
            s1_last_ff  <= req_last;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance && req_valid) begin
         s1_x_ff  <= req_x;
         s1_sq_ff <= $unsigned(ssstat_pkg::SQ_W'(req_x * req_x));
      end
   end

   a_count_limit: assert property (@(posedge clock) disable iff (reset)
      32'(acc_ff.count) <= 32'(ssstat_pkg::MAX_SAMPLES))
      else $error("sample count beyond limit");

   a_push_clears: assert property (@(posedge clock) disable iff (reset)
      push |=> (acc_ff.count == '0 && !acc_ff.dropped))
      else $error("accumulators not cleared after set end");

endmodule

`default_nettype wire

// ===== rtl/ssstat_queue.sv =====
// short queue of finished set totals between front and back end
`default_nettype none

module ssstat_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  ssstat_pkg::snap_type  push_snap,
   output logic                  full,
   input  logic                  pop,
   output ssstat_pkg::head_type  head
);

   ssstat_pkg::snap_type              entry_ff [ssstat_pkg::QUEUE_DEPTH];
   logic [ssstat_pkg::PTR_W-1:0]      wr_ptr_ff;
   logic [ssstat_pkg::PTR_W-1:0]      rd_ptr_ff;
   logic [ssstat_pkg::LVL_W-1:0]      level_ff;
   logic                              do_push;
   logic                              do_pop;

   assign full       = level_ff == ssstat_pkg::LVL_W'(ssstat_pkg::QUEUE_DEPTH);
   assign head.valid = level_ff != '0;
   assign head.snap  = entry_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head.valid;

   function automatic logic [ssstat_pkg::PTR_W-1:0] bump(input logic [ssstat_pkg::PTR_W-1:0] p);
      return (p == ssstat_pkg::PTR_W'(ssstat_pkg::QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= bump(wr_ptr_ff);
         end
         if (do_pop) begin
            rd_ptr_ff <= bump(rd_ptr_ff);
         end
         if (do_push && !do_pop) begin
            level_ff <= level_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            level_ff <= level_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_snap;
      end
   end

   a_level_bound: assert property (@(posedge clock) disable iff (reset)
      32'(level_ff) <= 32'(ssstat_pkg::QUEUE_DEPTH))
      else $error("queue level out of range");

   a_no_lost_push: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("push into full queue");

endmodule

`default_nettype wire

// ===== rtl/ssstat_back.sv =====
// back end: multiplies, divides and takes the square root for one set, holds the result word
`default_nettype none

module ssstat_back (
   input  logic                              clock,
   input  logic                              reset,
   input  ssstat_pkg::head_type              head,
   output logic                              pop,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [ssstat_pkg::CNT_W-1:0]      rsp_count,
   output logic signed [ssstat_pkg::SMP_W-1:0] rsp_minimum,
   output logic signed [ssstat_pkg::SMP_W-1:0] rsp_maximum,
   output logic signed [ssstat_pkg::MEAN_W-1:0] rsp_mean_q8,
   output logic [ssstat_pkg::SD_W-1:0]       rsp_stddev_q8,
   output logic                              rsp_overflow
);

   typedef enum logic [5:0] {
      S_IDLE     = 6'b000001,
      S_MUL      = 6'b000010,
      S_DIV_MEAN = 6'b000100,
      S_DIV_VAR  = 6'b001000,
      S_SQRT     = 6'b010000,
      S_OUT      = 6'b100000
   } state_type;

   state_type                               state_ff, state_in;
   ssstat_pkg::snap_type                    job_ff;
   logic                                    neg_ff;
   logic [ssstat_pkg::MAG_W-1:0]            mag_ff;
   logic [2:0]                              step_ff;
   logic [ssstat_pkg::PLO_W-1:0]            plo_ff;
   logic [ssstat_pkg::PHI_W-1:0]            phi_ff;
   logic [2*ssstat_pkg::MAG_W-1:0]          magsq_ff;
   logic [ssstat_pkg::N2_W-1:0]             n2_ff;
   logic [ssstat_pkg::VNUM_W-1:0]           nss_ff;
   logic [ssstat_pkg::VNUM_W-1:0]           vnum_ff;
   logic [ssstat_pkg::DIV_W-1:0]            dvd_ff;
   logic [ssstat_pkg::DVS_W-1:0]            rem_ff;
   logic [ssstat_pkg::DVS_W-1:0]            dvs_ff;
   logic [ssstat_pkg::ITER_W-1:0]           iter_ff;
   logic [ssstat_pkg::VQ_W-1:0]             rad_ff;
   logic [ssstat_pkg::ROOT_W-1:0]           root_ff;
   logic [ssstat_pkg::SREM_W-1:0]           srem_ff;
   logic [ssstat_pkg::MEAN_W-1:0]           mean_ff;
   logic [ssstat_pkg::SD_W-1:0]             sd_ff;
   logic                                    rsp_valid_ff;

   logic [ssstat_pkg::DVS_W:0]              div_shift;
   logic [ssstat_pkg::DVS_W+1:0]            div_diff;
   logic                                    div_ge;
   logic [ssstat_pkg::DVS_W-1:0]            rem_next;
   logic [ssstat_pkg::DIV_W-1:0]            dvd_next;
   logic [ssstat_pkg::SREM_W+1:0]           sq_shift;
   logic [ssstat_pkg::SREM_W+2:0]           sq_trial;
   logic                                    sq_ge;
   logic [ssstat_pkg::SREM_W-1:0]           srem_next;
   logic [ssstat_pkg::ROOT_W-1:0]           root_next;
   logic [ssstat_pkg::QUOT_W-1:0]           quot;
   logic [ssstat_pkg::QUOT_W-1:0]           quot_up;
   logic                                    last_iter;
   logic                                    out_load;

   // restoring divider step
   assign div_shift = {rem_ff, dvd_ff[ssstat_pkg::DIV_W-1]};
   assign div_diff  = {1'b0, div_shift} - {2'b0, dvs_ff};
   assign div_ge    = !div_diff[ssstat_pkg::DVS_W+1];
   assign rem_next  = div_ge ? div_diff[ssstat_pkg::DVS_W-1:0]
                             : div_shift[ssstat_pkg::DVS_W-1:0];
   assign dvd_next  = {dvd_ff[ssstat_pkg::DIV_W-2:0], div_ge};

   // digit-by-digit square root step
   assign sq_shift  = {srem_ff, rad_ff[ssstat_pkg::VQ_W-1 -: 2]};
   assign sq_trial  = {1'b0, sq_shift} - {3'b0, root_ff, 2'b01};
   assign sq_ge     = !sq_trial[ssstat_pkg::SREM_W+2];
   assign srem_next = sq_ge ? sq_trial[ssstat_pkg::SREM_W-1:0]
                            : sq_shift[ssstat_pkg::SREM_W-1:0];
   assign root_next = {root_ff[ssstat_pkg::ROOT_W-2:0], sq_ge};

   assign quot      = dvd_next[ssstat_pkg::QUOT_W-1:0];
   assign quot_up   = quot + ssstat_pkg::QUOT_W'(rem_next != '0);
   assign last_iter = iter_ff == ssstat_pkg::ITER_W'(1);
   assign out_load  = (state_ff == S_OUT) && (!rsp_valid_ff || rsp_ready);
   assign pop       = (state_ff == S_IDLE) && head.valid;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (head.valid) begin
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            if (step_ff == 3'd4) begin
               state_in = S_DIV_MEAN;
            end
         end
         S_DIV_MEAN: begin
            if (last_iter) begin
               state_in = S_DIV_VAR;
            end
         end
         S_DIV_VAR: begin
            if (last_iter) begin
               state_in = S_SQRT;
            end
         end
         S_SQRT: begin
            if (last_iter) begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (out_load) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         job_ff  <= head.snap;
         neg_ff  <= head.snap.sum < 0;
         mag_ff  <= (head.snap.sum < 0) ? ssstat_pkg::MAG_W'(-head.snap.sum)
                                        : ssstat_pkg::MAG_W'(head.snap.sum);
         step_ff <= '0;
      end
      if (state_ff == S_MUL) begin
         step_ff <= step_ff + 1'b1;
         case (step_ff)
            3'd0: plo_ff <= ssstat_pkg::PLO_W'(job_ff.count)
                            * ssstat_pkg::PLO_W'(job_ff.sumsq[ssstat_pkg::SSQ_LO_W-1:0]);
            3'd1: phi_ff <= ssstat_pkg::PHI_W'(job_ff.count)
                            * ssstat_pkg::PHI_W'(job_ff.sumsq[ssstat_pkg::SSQ_W-1:ssstat_pkg::SSQ_LO_W]);
            3'd2: begin
               magsq_ff <= (2*ssstat_pkg::MAG_W)'(mag_ff) * (2*ssstat_pkg::MAG_W)'(mag_ff);
               n2_ff    <= ssstat_pkg::N2_W'(job_ff.count) * ssstat_pkg::N2_W'(job_ff.count);
            end
            3'd3: nss_ff <= ssstat_pkg::VNUM_W'({phi_ff, {ssstat_pkg::SSQ_LO_W{1'b0}}})
                            + ssstat_pkg::VNUM_W'(plo_ff);
            3'd4: begin
               vnum_ff <= nss_ff - ssstat_pkg::VNUM_W'(magsq_ff);
               dvd_ff  <= ssstat_pkg::DIV_W'({mag_ff, 8'b0})
                          << (ssstat_pkg::DIV_W - ssstat_pkg::MEAN_ITERS);
               rem_ff  <= '0;
               dvs_ff  <= ssstat_pkg::DVS_W'(job_ff.count);
               iter_ff <= ssstat_pkg::ITER_W'(ssstat_pkg::MEAN_ITERS);
            end
            default: ;
         endcase
      end
      if (state_ff == S_DIV_MEAN) begin
         if (last_iter) begin
            mean_ff <= neg_ff ? ssstat_pkg::MEAN_W'(-quot_up) : ssstat_pkg::MEAN_W'(quot);
            dvd_ff  <= {vnum_ff, 16'b0};
            rem_ff  <= '0;
            dvs_ff  <= n2_ff;
            iter_ff <= ssstat_pkg::ITER_W'(ssstat_pkg::DIV_W);
         end else begin
            dvd_ff  <= dvd_next;
            rem_ff  <= rem_next;
            iter_ff <= iter_ff - 1'b1;
         end
      end
      if (state_ff == S_DIV_VAR) begin
         if (last_iter) begin
            rad_ff  <= dvd_next[ssstat_pkg::VQ_W-1:0];
            root_ff <= '0;
            srem_ff <= '0;
            iter_ff <= ssstat_pkg::ITER_W'(ssstat_pkg::ROOT_W);
         end else begin
            dvd_ff  <= dvd_next;
            rem_ff  <= rem_next;
            iter_ff <= iter_ff - 1'b1;
         end
      end
      if (state_ff == S_SQRT) begin
         rad_ff  <= rad_ff << 2;
         root_ff <= root_next;
         srem_ff <= srem_next;
         iter_ff <= iter_ff - 1'b1;
         if (last_iter) begin
            sd_ff <= root_next[ssstat_pkg::SD_W-1:0];
         end
      end
      if (out_load) begin
         rsp_count     <= job_ff.count;
         rsp_minimum   <= job_ff.minimum;
         rsp_maximum   <= job_ff.maximum;
         rsp_mean_q8   <= mean_ff;
         rsp_stddev_q8 <= sd_ff;
         rsp_overflow  <= job_ff.dropped;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   a_pop_starts: assert property (@(posedge clock) disable iff (reset)
      pop |=> (state_ff == S_MUL))
      else $error("set taken from queue but work not started");

   a_sqrt_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SQRT && last_iter) |=> (state_ff == S_OUT))
      else $error("square root did not finish in order");

   a_out_shown: assert property (@(posedge clock) disable iff (reset)
      out_load |=> rsp_valid_ff)
      else $error("result word loaded but not shown");

endmodule

`default_nettype wire

// ===== tb/sample_set_statistics_checker.sv =====
// checker for the sample set statistics block: predicts each result word and compares it
module sample_set_statistics_checker (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   input  logic                                 req_ready,
   input  logic signed [ssstat_pkg::SMP_W-1:0]  req_sample,
   input  logic                                 req_last,
   input  logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   input  logic [ssstat_pkg::CNT_W-1:0]         rsp_count,
   input  logic signed [ssstat_pkg::SMP_W-1:0]  rsp_minimum,
   input  logic signed [ssstat_pkg::SMP_W-1:0]  rsp_maximum,
   input  logic signed [ssstat_pkg::MEAN_W-1:0] rsp_mean_q8,
   input  logic [ssstat_pkg::SD_W-1:0]          rsp_stddev_q8,
   input  logic                                 rsp_overflow,
   output int                                   mismatches,
   output int                                   sets_pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [ssstat_pkg::CNT_W-1:0]         count;
      logic signed [ssstat_pkg::SMP_W-1:0]  minimum;
      logic signed [ssstat_pkg::SMP_W-1:0]  maximum;
      logic signed [ssstat_pkg::MEAN_W-1:0] mean_q8;
      logic [ssstat_pkg::SD_W-1:0]          stddev_q8;
      logic                                 overflow;
   } set_stats_type;

   set_stats_type expected_stats[$];

   logic [ssstat_pkg::CNT_W-1:0]        acc_count;
   logic signed [63:0]                  acc_sum;
   logic [63:0]                         acc_sumsq;
   logic signed [ssstat_pkg::SMP_W-1:0] acc_min;
   logic signed [ssstat_pkg::SMP_W-1:0] acc_max;
   logic                                acc_dropped;

   function automatic void clear_accumulators();
      acc_count   = '0;
      acc_sum     = '0;
      acc_sumsq   = '0;
      acc_min     = '0;
      acc_max     = '0;
      acc_dropped = 1'b0;
   endfunction

   function automatic set_stats_type close_set_stats();
      set_stats_type s;
      logic [63:0] n, mag, quo, var_num, n2, q, r, vq, root, trial;
      n   = 64'(acc_count);
      mag = acc_sum[63] ? 64'(-acc_sum) : 64'(acc_sum);
      // mean rounds toward minus infinity
      if (acc_sum[63]) begin
         quo = ((mag << 8) + n - 64'd1) / n;
         quo = -quo;
      end else begin
         quo = (mag << 8) / n;
      end
      var_num = n * acc_sumsq - mag * mag;
      n2      = n * n;
      q       = var_num / n2;
      r       = var_num % n2;
      vq      = (q << 16) + ((r << 16) / n2);
      root    = '0;
      for (int b = 27; b >= 0; b--) begin
         trial = root | (64'd1 << b);
         if (trial * trial <= vq) root = trial;
      end
      s.count     = acc_count;
      s.minimum   = acc_min;
      s.maximum   = acc_max;
      s.mean_q8   = quo[ssstat_pkg::MEAN_W-1:0];
      s.stddev_q8 = root[ssstat_pkg::SD_W-1:0];
      s.overflow  = acc_dropped;
      return s;
   endfunction

   task automatic check_field(input string name, input longint want, input longint got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      set_stats_type                       want;
      logic signed [ssstat_pkg::SMP_W-1:0] x;
      logic signed [63:0]                  xl;
      if (reset) begin
         clear_accumulators();
         expected_stats.delete();
         mismatches = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_stats.size() == 0) begin
               $error("result word with no set pending");
               mismatches++;
            end else begin
               want = expected_stats.pop_front();
               check_field("count", want.count, rsp_count);
               check_field("minimum", want.minimum, rsp_minimum);
               check_field("maximum", want.maximum, rsp_maximum);
               check_field("mean_q8", want.mean_q8, rsp_mean_q8);
               check_field("stddev_q8", want.stddev_q8, rsp_stddev_q8);
               check_field("overflow", want.overflow, rsp_overflow);
            end
         end
         if (req_valid && req_ready) begin
            x  = req_sample <<< (ssstat_pkg::SMP_W - ssstat_pkg::SX_BITS);
            x  = x >>> (ssstat_pkg::SMP_W - ssstat_pkg::SX_BITS);
            xl = x;
            if (acc_count >= ssstat_pkg::MAX_SAMPLES) begin
               acc_dropped = 1'b1;
            end else begin
               if (acc_count == 0 || x < acc_min) acc_min = x;
               if (acc_count == 0 || x > acc_max) acc_max = x;
               acc_sum   = acc_sum + xl;
               acc_sumsq = acc_sumsq + 64'(xl * xl);
               acc_count = acc_count + 1'b1;
            end
            if (req_last) begin
               expected_stats.push_back(close_set_stats());
               clear_accumulators();
            end
         end
      end
      sets_pending = expected_stats.size();
   end

endmodule

// ===== tb/sample_set_statistics_tb.sv =====
// testbench top for the sample set statistics block: stimulus, flow control and verdict
module sample_set_statistics_tb;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int HOLD_CYCLES = 1500;

   logic                                 clock;
   logic                                 reset;
   logic                                 req_valid;
   logic                                 req_ready;
   logic signed [ssstat_pkg::SMP_W-1:0]  req_sample;
   logic                                 req_last;
   logic                                 rsp_valid;
   logic                                 rsp_ready;
   logic [ssstat_pkg::CNT_W-1:0]         rsp_count;
   logic signed [ssstat_pkg::SMP_W-1:0]  rsp_minimum;
   logic signed [ssstat_pkg::SMP_W-1:0]  rsp_maximum;
   logic signed [ssstat_pkg::MEAN_W-1:0] rsp_mean_q8;
   logic [ssstat_pkg::SD_W-1:0]          rsp_stddev_q8;
   logic                                 rsp_overflow;

   int mismatches;
   int sets_pending;
   int words_sent;
   bit quiet_tail;
   bit backpressure_req;
   bit backpressure_on;

   sample_set_statistics i_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_sample    (req_sample),
      .req_last      (req_last),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_count     (rsp_count),
      .rsp_minimum   (rsp_minimum),
      .rsp_maximum   (rsp_maximum),
      .rsp_mean_q8   (rsp_mean_q8),
      .rsp_stddev_q8 (rsp_stddev_q8),
      .rsp_overflow  (rsp_overflow)
   );

   sample_set_statistics_checker i_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_sample    (req_sample),
      .req_last      (req_last),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_count     (rsp_count),
      .rsp_minimum   (rsp_minimum),
      .rsp_maximum   (rsp_maximum),
      .rsp_mean_q8   (rsp_mean_q8),
      .rsp_stddev_q8 (rsp_stddev_q8),
      .rsp_overflow  (rsp_overflow),
      .mismatches    (mismatches),
      .sets_pending  (sets_pending)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("FAILURE");
      $finish;
   end

   // result side flow control
   initial begin
      rsp_ready = 1'b0;
      @(negedge clock);
      forever begin
         if (backpressure_req && !backpressure_on) begin
            rsp_ready = 1'b0;
            backpressure_on = 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
         end else if (!quiet_tail && $urandom_range(0, 3) == 0) begin
            rsp_ready = 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge clock);
         end else begin
            rsp_ready = 1'b1;
            repeat ($urandom_range(1, 30)) @(negedge clock);
         end
      end
   end

   task automatic send_sample(input logic signed [ssstat_pkg::SMP_W-1:0] s,
                              input logic mark_last);
      @(negedge clock);
      if (!quiet_tail && !backpressure_req && $urandom_range(0, 3) == 0) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 18)) @(negedge clock);
      end
      req_valid  = 1'b1;
      req_sample = s;
      req_last   = mark_last;
      do @(posedge clock); while (!req_ready);
      words_sent++;
   endtask

   task automatic send_random_set(input int len);
      int                                  style;
      int                                  k;
      logic signed [ssstat_pkg::SMP_W-1:0] base;
      logic signed [ssstat_pkg::SMP_W-1:0] s;
      style = $urandom_range(0, 3);
      k     = $urandom_range(1, 15);
      base  = ssstat_pkg::SMP_W'($urandom);
      for (int i = 0; i < len; i++) begin
         case (style)
            0: s = ssstat_pkg::SMP_W'($urandom);
            1: s = base ^ ssstat_pkg::SMP_W'($urandom & ((1 << k) - 1));
            2: s = base;
            default: s = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
         endcase
         send_sample(s, i == len - 1);
      end
   endtask

   function automatic int pick_set_length();
      if ($urandom_range(0, 7) == 0) return $urandom_range(13, 64);
      return $urandom_range(1, 12);
   endfunction

   initial begin
      int start;
      int waited;
      reset      = 1'b1;
      req_valid  = 1'b0;
      req_sample = '0;
      req_last   = 1'b0;
      repeat (11) @(negedge clock);
      reset = 1'b0;

      // single word sets at the extremes
      send_sample(16'sh8000, 1'b1);
      send_sample(16'sh7fff, 1'b1);
      send_sample(16'sh0000, 1'b1);
      // widest spread
      send_sample(16'sh8000, 1'b0);
      send_sample(16'sh7fff, 1'b1);
      // negative mean that needs rounding down, then a mixed-sign set
      send_sample(-16'sd1, 1'b0);
      send_sample(16'sd0, 1'b0);
      send_sample(16'sd0, 1'b1);
      send_sample(16'sd7, 1'b0);
      send_sample(-16'sd3, 1'b0);
      send_sample(16'sd100, 1'b0);
      send_sample(-16'sd100, 1'b1);
      // long set at the most negative value
      for (int i = 0; i < 64; i++) send_sample(16'sh8000, i == 63);

      start = words_sent;
      while (words_sent - start < 180) send_random_set(pick_set_length());

      // fill the block while results are held back
      @(negedge clock);
      backpressure_req = 1'b1;
      while (!backpressure_on) @(negedge clock);
      for (int i = 0; i < 40; i++) send_random_set($urandom_range(1, 3));
      backpressure_req = 1'b0;

      start = words_sent;
      while (words_sent - start < 180) send_random_set(pick_set_length());

      quiet_tail = 1'b1;
      start = words_sent;
      while (words_sent - start < 140) send_random_set(pick_set_length());

      @(negedge clock);
      req_valid = 1'b0;
      waited = 0;
      while (sets_pending != 0 && waited < 20000) begin
         @(negedge clock);
         waited++;
      end
      repeat (300) @(negedge clock);
      if (mismatches == 0 && sets_pending == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/ssstat_pkg.sv
rtl/ssstat_front.sv
rtl/ssstat_queue.sv
rtl/ssstat_back.sv
rtl/sample_set_statistics.sv
tb/sample_set_statistics_checker.sv
tb/sample_set_statistics_tb.sv
